FILE: rtl/spectrum_bins_to_db_bands_unit_defines.svh
// Assertion macros for the spectrum band unit.
`ifndef SPECTRUM_BINS_TO_DB_BANDS_UNIT_DEFINES_SVH
`define SPECTRUM_BINS_TO_DB_BANDS_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define SBDB_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define SBDB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SBDB_ASSERT_NOW(label, clk, rst, ante, cons, msg)
`define SBDB_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

FILE: rtl/sbdb_pkg.sv
package sbdb_pkg;

  localparam int BIN_BITS   = 9;
  localparam int BAND_BITS  = 7;
  localparam int LEVEL_BITS = 8;
  localparam int POWER_BITS = 16;
  localparam int MAG_BITS   = 17;  // |x| of a 16-bit value, up to 32768
  localparam int SQ_BITS    = 31;  // 32768^2 = 2^30
  localparam int POWER_SHIFT = 15;

  localparam logic [BIN_BITS-1:0]   BIN_LAST    = 9'd511;
  localparam logic [BAND_BITS-1:0]  BAND_LAST   = 7'd127;
  localparam logic [LEVEL_BITS-1:0] LEVEL_TOP   = 8'd254;
  localparam logic [BIN_BITS-1:0]   SINGLE_END  = 9'd48;
  localparam logic [BIN_BITS-1:0]   PAIR_END    = 9'd96;
  localparam logic [BIN_BITS-1:0]   QUAD_END    = 9'd192;
  localparam logic [BIN_BITS-1:0]   OCTET_END   = 9'd384;

  // pipeline tag traveling with each bin
  typedef struct packed {
    logic                valid;
    logic [BIN_BITS-1:0] bin;
  } tag_t;

  // dB thresholds, strictly increasing; entries 0..254 are searched
  localparam logic [POWER_BITS-1:0] LEVEL_TABLE [0:255] = '{
    16'd256,   16'd262,   16'd267,   16'd273,   16'd279,   16'd285,   16'd292,   16'd298,
    16'd305,   16'd311,   16'd318,   16'd325,   16'd332,   16'd340,   16'd347,   16'd355,
    16'd363,   16'd370,   16'd379,   16'd387,   16'd395,   16'd404,   16'd413,   16'd422,
    16'd431,   16'd441,   16'd451,   16'd460,   16'd471,   16'd481,   16'd492,   16'd502,
    16'd513,   16'd525,   16'd536,   16'd548,   16'd560,   16'd572,   16'd585,   16'd598,
    16'd611,   16'd624,   16'd638,   16'd652,   16'd666,   16'd681,   16'd696,   16'd711,
    16'd727,   16'd743,   16'd759,   16'd776,   16'd793,   16'd811,   16'd828,   16'd847,
    16'd865,   16'd884,   16'd904,   16'd923,   16'd944,   16'd965,   16'd986,   16'd1007,
    16'd1030,  16'd1052,  16'd1075,  16'd1099,  16'd1123,  16'd1148,  16'd1173,  16'd1199,
    16'd1225,  16'd1252,  16'd1280,  16'd1308,  16'd1337,  16'd1366,  16'd1396,  16'd1427,
    16'd1458,  16'd1490,  16'd1523,  16'd1556,  16'd1591,  16'd1625,  16'd1661,  16'd1698,
    16'd1735,  16'd1773,  16'd1812,  16'd1852,  16'd1893,  16'd1934,  16'd1977,  16'd2020,
    16'd2065,  16'd2110,  16'd2157,  16'd2204,  16'd2252,  16'd2302,  16'd2353,  16'd2404,
    16'd2457,  16'd2511,  16'd2566,  16'd2623,  16'd2680,  16'd2739,  16'd2800,  16'd2861,
    16'd2924,  16'd2988,  16'd3054,  16'd3121,  16'd3190,  16'd3260,  16'd3331,  16'd3405,
    16'd3480,  16'd3556,  16'd3634,  16'd3714,  16'd3796,  16'd3879,  16'd3965,  16'd4052,
    16'd4141,  16'd4232,  16'd4325,  16'd4420,  16'd4517,  16'd4616,  16'd4718,  16'd4822,
    16'd4928,  16'd5036,  16'd5147,  16'd5260,  16'd5375,  16'd5494,  16'd5614,  16'd5738,
    16'd5864,  16'd5993,  16'd6124,  16'd6259,  16'd6397,  16'd6537,  16'd6681,  16'd6828,
    16'd6978,  16'd7131,  16'd7288,  16'd7448,  16'd7612,  16'd7780,  16'd7951,  16'd8125,
    16'd8304,  16'd8487,  16'd8673,  16'd8864,  16'd9059,  16'd9258,  16'd9461,  16'd9669,
    16'd9882,  16'd10099, 16'd10321, 16'd10548, 16'd10780, 16'd11017, 16'd11259, 16'd11507,
    16'd11760, 16'd12018, 16'd12282, 16'd12552, 16'd12828, 16'd13110, 16'd13399, 16'd13693,
    16'd13994, 16'd14302, 16'd14616, 16'd14937, 16'd15266, 16'd15601, 16'd15944, 16'd16295,
    16'd16653, 16'd17019, 16'd17393, 16'd17776, 16'd18167, 16'd18566, 16'd18974, 16'd19391,
    16'd19818, 16'd20253, 16'd20698, 16'd21153, 16'd21619, 16'd22094, 16'd22579, 16'd23076,
    16'd23583, 16'd24102, 16'd24631, 16'd25173, 16'd25726, 16'd26292, 16'd26870, 16'd27461,
    16'd28064, 16'd28681, 16'd29312, 16'd29956, 16'd30615, 16'd31288, 16'd31976, 16'd32679,
    16'd33397, 16'd34131, 16'd34882, 16'd35648, 16'd36432, 16'd37233, 16'd38051, 16'd38888,
    16'd39743, 16'd40617, 16'd41510, 16'd42422, 16'd43355, 16'd44308, 16'd45282, 16'd46277,
    16'd47295, 16'd48334, 16'd49397, 16'd50483, 16'd51593, 16'd52727, 16'd53886, 16'd55071,
    16'd56281, 16'd57519, 16'd58783, 16'd60075, 16'd61396, 16'd62746, 16'd64125, 16'd65535
  };

  // true for the last bin of a band
  function automatic logic ends_band(input logic [BIN_BITS-1:0] i);
    ends_band = (i < SINGLE_END) ||
                ((i < PAIR_END)  && (i[0] == 1'b1)) ||
                ((i < QUAD_END)  && (i[1:0] == 2'b11)) ||
                ((i < OCTET_END) && (i[2:0] == 3'b111)) ||
                (i[3:0] == 4'b1111);
  endfunction

endpackage

FILE: rtl/sbdb_level_search.sv
// Binary search of the threshold ROM, one bit of the level per stage.
module sbdb_level_search (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  sbdb_pkg::tag_t                    tag_in,
  input  logic [sbdb_pkg::POWER_BITS-1:0]   power,
  output sbdb_pkg::tag_t                    tag_out,
  output logic [sbdb_pkg::LEVEL_BITS-1:0]   level
);
  import sbdb_pkg::*;

  localparam int STEPS = LEVEL_BITS;

  // d_*[k]: what enters step k; d_*[STEPS] leaves the search
  tag_t                  d_tag [0:STEPS];
  logic [POWER_BITS-1:0] d_pw  [0:STEPS];
  logic [LEVEL_BITS-1:0] d_cnt [0:STEPS];

  tag_t                  r_tag  [1:STEPS];
  logic [POWER_BITS-1:0] r_pw   [1:STEPS];
  logic [LEVEL_BITS-1:0] r_cand [1:STEPS];
  logic [LEVEL_BITS-1:0] r_base [1:STEPS];
  logic [POWER_BITS-1:0] r_q    [1:STEPS];

  assign d_tag[0] = tag_in;
  assign d_pw[0]  = power;
  assign d_cnt[0] = '0;

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    localparam logic [LEVEL_BITS-1:0] STEP_BIT = LEVEL_BITS'(1) << (STEPS - 1 - k);
    logic [LEVEL_BITS-1:0] cand;
    assign cand = d_cnt[k] | STEP_BIT;

    always_ff @(posedge clk) begin
      if (rst) begin
        r_tag[k+1] <= '0;
      end else if (en) begin
        r_tag[k+1] <= d_tag[k];
      end
    end

    // registered ROM read at cand-1 (never below 0 since cand has STEP_BIT set)
    always_ff @(posedge clk) begin
      if (en) begin
        r_pw[k+1]   <= d_pw[k];
        r_cand[k+1] <= cand;
        r_base[k+1] <= d_cnt[k];
        r_q[k+1]    <= LEVEL_TABLE[cand - LEVEL_BITS'(1)];
      end
    end

    assign d_tag[k+1] = r_tag[k+1];
    assign d_pw[k+1]  = r_pw[k+1];
    assign d_cnt[k+1] = (r_q[k+1] < r_pw[k+1]) ? r_cand[k+1] : r_base[k+1];
  end

  // count of entries below power, minus one; tops out at 254 by construction
  assign tag_out = d_tag[STEPS];
  assign level   = (d_cnt[STEPS] == '0) ? '0 : d_cnt[STEPS] - LEVEL_BITS'(1);

endmodule

FILE: rtl/spectrum_bins_to_db_bands_unit.sv
// Spectrum band unit: takes one complex FFT bin per beat (512 bins a frame,
// counted internally), forms power = (re^2 + im^2) >> 15 on 16 bits, maps it
// to a dB level 0..254 against a fixed threshold ROM, and emits the maximum
// level of each of 128 log-spaced bands on the band's last bin. Throughput is
// one bin per cycle while the result side does not stall. The squares register
// at the taking edge, then the sum register, then eight binary search stages
// (one registered ROM read per level bit), then the band maximum and output
// register. A stalled result holds the whole pipeline; bin_ready drops only
// while band_valid is high and band_ready low.
`include "spectrum_bins_to_db_bands_unit_defines.svh"

module spectrum_bins_to_db_bands_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              bin_valid,
  output logic                              bin_ready,
  input  logic signed [15:0]                bin_real,
  input  logic signed [15:0]                bin_imag,
  output logic                              band_valid,
  input  logic                              band_ready,
  output logic [sbdb_pkg::BAND_BITS-1:0]    band_number,
  output logic [sbdb_pkg::LEVEL_BITS-1:0]   band_level,
  output logic                              frame_end
);
  import sbdb_pkg::*;

  logic                  en;
  logic                  accept;
  logic [BIN_BITS-1:0]   bin_count;
  tag_t                  in_tag;

  logic [MAG_BITS-1:0]   mag_re, mag_im;
  logic [2*MAG_BITS-1:0] prod_re, prod_im;
  tag_t                  a_tag;
  logic [SQ_BITS-1:0]    a_sq_re, a_sq_im;
  logic [SQ_BITS:0]      sum;
  tag_t                  b_tag;
  logic [POWER_BITS-1:0] b_power;

  tag_t                  s_tag;
  logic [LEVEL_BITS-1:0] s_level;

  logic [BAND_BITS-1:0]  band_count;
  logic [LEVEL_BITS-1:0] run_max;
  logic [LEVEL_BITS-1:0] band_max;
  logic                  last_of_band;

  assign en        = !band_valid || band_ready;
  assign bin_ready = en;
  assign accept    = bin_valid && bin_ready;

  assign in_tag.valid = accept;
  assign in_tag.bin   = bin_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_count <= '0;
    end else if (accept) begin
      bin_count <= bin_count + BIN_BITS'(1);  // wraps at frame end
    end
  end

  // absolute values; -32768 becomes 32768
  assign mag_re  = bin_real[15] ? (MAG_BITS'(0) - MAG_BITS'(bin_real)) : MAG_BITS'(bin_real);
  assign mag_im  = bin_imag[15] ? (MAG_BITS'(0) - MAG_BITS'(bin_imag)) : MAG_BITS'(bin_imag);
  assign prod_re = (2*MAG_BITS)'(mag_re) * (2*MAG_BITS)'(mag_re);
  assign prod_im = (2*MAG_BITS)'(mag_im) * (2*MAG_BITS)'(mag_im);
  assign sum     = {1'b0, a_sq_re} + {1'b0, a_sq_im};

  always_ff @(posedge clk) begin
    if (rst) begin
      a_tag <= '0;
      b_tag <= '0;
    end else if (en) begin
      a_tag <= in_tag;
      b_tag <= a_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_sq_re <= prod_re[SQ_BITS-1:0];
      a_sq_im <= prod_im[SQ_BITS-1:0];
      // low 16 bits of sum >> 15: both parts at -32768 give 0
      b_power <= sum[POWER_SHIFT+POWER_BITS-1:POWER_SHIFT];
    end
  end

  sbdb_level_search u_search (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .tag_in  (b_tag),
    .power   (b_power),
    .tag_out (s_tag),
    .level   (s_level)
  );

  assign band_max     = (s_level > run_max) ? s_level : run_max;
  assign last_of_band = ends_band(s_tag.bin);

  always_ff @(posedge clk) begin
    if (rst) begin
      band_valid <= 1'b0;
      band_count <= '0;
      run_max    <= '0;
    end else if (en) begin
      band_valid <= s_tag.valid && last_of_band;
      if (s_tag.valid) begin
        if (last_of_band) begin
          band_count <= band_count + BAND_BITS'(1);
          run_max    <= '0;
        end else begin
          run_max    <= band_max;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && s_tag.valid && last_of_band) begin
      band_number <= band_count;
      band_level  <= band_max;
      frame_end   <= (s_tag.bin == BIN_LAST);
    end
  end

  `SBDB_ASSERT_NOW(a_frame_end_band, clk, rst, band_valid && frame_end, band_number == BAND_LAST, "frame end on a band other than the last")
  `SBDB_ASSERT_NOW(a_level_range, clk, rst, band_valid, band_level <= LEVEL_TOP, "band level above top of table")
  `SBDB_ASSERT_NEXT(a_stall_holds, clk, rst, band_valid && !band_ready, band_valid && $stable(band_number) && $stable(band_level), "stalled band beat changed")

endmodule

FILE: dv/tb_spectrum_bins_to_db_bands_unit.sv
module tb_spectrum_bins_to_db_bands_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import sbdb_pkg::*;

  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned DRAIN_CYCLES = 30;

  localparam logic signed [15:0] CORNER_VALUES [6] = '{
    16'sh8000, 16'sh7FFF, 16'sh8001, 16'sh0000, 16'sh0001, 16'shFFFF
  };

  // Tracks bin/band position and the running band peak, predicts every band beat.
  class band_scoreboard;
    typedef struct {
      logic [BAND_BITS-1:0]  number;
      logic [LEVEL_BITS-1:0] level;
      logic                  frame_done;
    } band_beat_t;

    band_beat_t expected_bands[$];
    logic [BIN_BITS-1:0]   bin_index;
    logic [BAND_BITS-1:0]  band_index;
    logic [LEVEL_BITS-1:0] peak_level;
    int unsigned bins_seen, bands_seen, frames_seen, top_levels, zero_levels;
    int unsigned errors, shown;

    function new();
      bin_index   = '0;
      band_index  = '0;
      peak_level  = '0;
      bins_seen   = 0;
      bands_seen  = 0;
      frames_seen = 0;
      top_levels  = 0;
      zero_levels = 0;
      errors      = 0;
      shown       = 0;
    endfunction

    function logic [MAG_BITS-1:0] magnitude(logic signed [15:0] v);
      return v[15] ? (17'h10000 - {1'b0, v}) : {1'b0, v};
    endfunction

    // highest threshold index strictly below the power, clamped to the top level
    function logic [LEVEL_BITS-1:0] db_level(logic [POWER_BITS-1:0] power);
      logic [LEVEL_BITS-1:0] lvl;
      lvl = '0;
      for (int k = 0; k <= int'(LEVEL_TOP); k++) begin
        if (LEVEL_TABLE[k] < power) lvl = LEVEL_BITS'(k);
      end
      return lvl;
    endfunction

    function void note_bin(logic signed [15:0] re, logic signed [15:0] im);
      logic [MAG_BITS-1:0]   mr, mi;
      logic [31:0]           energy;
      logic [POWER_BITS-1:0] power;
      logic [LEVEL_BITS-1:0] lvl;
      logic                  closes;
      band_beat_t            beat;
      mr = magnitude(re);
      mi = magnitude(im);
      energy = {15'b0, mr} * {15'b0, mr} + {15'b0, mi} * {15'b0, mi};
      // >> 15 and keep 16 bits; a sum of exactly 2^31 folds to zero
      power = energy[30:15];
      lvl = db_level(power);
      if (lvl > peak_level) peak_level = lvl;
      closes = (bin_index < SINGLE_END) ||
               ((bin_index < PAIR_END) && bin_index[0]) ||
               ((bin_index < QUAD_END) && (&bin_index[1:0])) ||
               ((bin_index < OCTET_END) && (&bin_index[2:0])) ||
               (&bin_index[3:0]);
      if (closes) begin
        beat.number     = band_index;
        beat.level      = peak_level;
        beat.frame_done = (bin_index == BIN_LAST);
        expected_bands.push_back(beat);
        band_index = band_index + 1'b1;
        peak_level = '0;
      end
      bin_index = bin_index + 1'b1;
      bins_seen++;
    endfunction

    function void check_band(logic [BAND_BITS-1:0] number, logic [LEVEL_BITS-1:0] level,
                             logic frame_done);
      band_beat_t beat;
      bands_seen++;
      if (frame_done) frames_seen++;
      if (level == LEVEL_TOP) top_levels++;
      if (level == '0) zero_levels++;
      if (expected_bands.size() == 0) begin
        errors++;
        if (shown < 10) begin
          shown++;
          $display("unexpected band beat: number=%0d level=%0d frame_end=%0b",
                   number, level, frame_done);
        end
        return;
      end
      beat = expected_bands.pop_front();
      if (number !== beat.number || level !== beat.level || frame_done !== beat.frame_done)
      begin
        errors++;
        if (shown < 10) begin
          shown++;
          $display("band mismatch: exp number=%0d level=%0d frame_end=%0b, got number=%0d level=%0d frame_end=%0b",
                   beat.number, beat.level, beat.frame_done, number, level, frame_done);
        end
      end
    endfunction

    function int unsigned pending();
      return expected_bands.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic bin_valid = 1'b0;
  logic bin_ready;
  logic signed [15:0] bin_real = '0;
  logic signed [15:0] bin_imag = '0;
  logic band_valid;
  logic band_ready = 1'b1;
  logic [BAND_BITS-1:0]  band_number;
  logic [LEVEL_BITS-1:0] band_level;
  logic frame_end;

  bit tx_idle_en = 1'b0;
  bit rx_idle_en = 1'b0;
  int unsigned quiet_cycles = 0;
  band_scoreboard sb = new();

  spectrum_bins_to_db_bands_unit u_top (
    .clk         (clk),
    .rst         (rst),
    .bin_valid   (bin_valid),
    .bin_ready   (bin_ready),
    .bin_real    (bin_real),
    .bin_imag    (bin_imag),
    .band_valid  (band_valid),
    .band_ready  (band_ready),
    .band_number (band_number),
    .band_level  (band_level),
    .frame_end   (frame_end)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (bin_valid && bin_ready) sb.note_bin(bin_real, bin_imag);
      if (band_valid && band_ready) sb.check_band(band_number, band_level, frame_end);
    end
  end

  // watchdog: cycles with no beat on either channel
  always @(posedge clk) begin
    if (rst || (bin_valid && bin_ready) || (band_valid && band_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("timeout: no beat for %0d cycles", STALL_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // result-side back-pressure in bursts
  initial begin
    forever begin
      @(posedge clk);
      if (rx_idle_en && $urandom_range(0, 7) == 0) begin
        band_ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        band_ready <= 1'b1;
      end
    end
  end

  task automatic send_bin(input logic signed [15:0] re, input logic signed [15:0] im);
    if (tx_idle_en && $urandom_range(0, 5) == 0) begin
      bin_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    bin_valid <= 1'b1;
    bin_real  <= re;
    bin_imag  <= im;
    do @(posedge clk); while (!bin_ready);
  endtask

  function automatic logic signed [15:0] near_zero(input int unsigned span);
    logic signed [15:0] v;
    v = 16'($urandom_range(0, span));
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  task automatic send_random_bin();
    logic signed [15:0] re, im;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        re = 16'($urandom);
        im = 16'($urandom);
      end
      3, 4, 5: begin
        // low power, around the bottom of the threshold table
        re = near_zero(4000);
        im = near_zero(4000);
      end
      6, 7: begin
        re = 16'($urandom);
        im = near_zero(255);
      end
      8: begin
        re = CORNER_VALUES[$urandom_range(0, 5)];
        im = CORNER_VALUES[$urandom_range(0, 5)];
      end
      default: begin
        re = near_zero(20);
        im = near_zero(20);
      end
    endcase
    send_bin(re, im);
  endtask

  task automatic wait_for_bands();
    bin_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: the first 48 bins are single-bin bands, so each gives a beat
    rx_idle_en = 1'b1;
    send_bin(16'sh0000, 16'sh0000);
    send_bin(16'sh8000, 16'sh8000);  // sum of 2^31 wraps the power to zero
    send_bin(16'sh7FFF, 16'sh7FFF);  // above the top threshold: saturates
    send_bin(16'sh8000, 16'sh0000);
    send_bin(16'sh0000, 16'sh8000);
    send_bin(16'sh7FFF, 16'sh8000);
    send_bin(16'sh8001, 16'sh8001);
    send_bin(16'sh7FFF, 16'sh0000);
    send_bin(16'sh0000, 16'sh7FFF);
    send_bin(16'sd2897, 16'sd0);     // power equal to the first threshold
    send_bin(16'sd2930, 16'sd0);     // just below the second threshold
    send_bin(16'sd2940, 16'sd0);     // just above it
    send_bin(-16'sd2940, 16'sd0);
    send_bin(16'sh0001, 16'shFFFF);
    send_bin(16'sh5555, 16'shAAAA);
    send_bin(16'shAAAA, 16'sh5555);
    send_bin(16'sd0, -16'sd14000);

    tx_idle_en = 1'b1;
    repeat (300) send_random_bin();

    wait_for_bands();

    tx_idle_en = 1'b0;
    repeat (120) send_random_bin();
    tx_idle_en = 1'b1;
    repeat (130) send_random_bin();

    // closing stretch at full rate on both sides
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    repeat (180) send_random_bin();

    wait_for_bands();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d bins and %0d band beats: %0d frame ends, %0d saturated, %0d at zero",
             sb.bins_seen, sb.bands_seen, sb.frames_seen, sb.top_levels, sb.zero_levels);
    $display("Band mismatches: %0d, expectations left: %0d", sb.errors, sb.pending());
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: spectrum_bins_to_db_bands_unit.f
+incdir+rtl
rtl/sbdb_pkg.sv
rtl/sbdb_level_search.sv
rtl/spectrum_bins_to_db_bands_unit.sv
dv/tb_spectrum_bins_to_db_bands_unit.sv
